// File: design/vat_pkg.sv
// ----------------------------------------------------------------------------
// vat_pkg
// Shared constants and types for the vertex affine transform.
// ----------------------------------------------------------------------------
package vat_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;

  localparam int NUM_COEF    = 16;
  localparam int COEF_IDX_W  = 4;
  localparam int NUM_ROWS    = 3;

  localparam logic ACTION_WRITE = 1'b0;
  localparam logic ACTION_XFORM = 1'b1;

  // per-stage load enables of the datapath pipeline
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } vat_adv_t;

endpackage

// File: design/vat_in_if.sv
// ----------------------------------------------------------------------------
// vat_in_if
// Input channel: coefficient writes and vertices.
// ----------------------------------------------------------------------------
interface vat_in_if #(
  parameter int COORD_WIDTH = vat_pkg::COORD_WIDTH
) ();
  logic                                 valid;
  logic                                 ready;
  logic                                 action;
  logic [vat_pkg::COEF_IDX_W-1:0]       coef_index;
  logic signed [COORD_WIDTH-1:0]        coef_value;
  logic signed [COORD_WIDTH-1:0]        in_x;
  logic signed [COORD_WIDTH-1:0]        in_y;
  logic signed [COORD_WIDTH-1:0]        in_z;
  logic                                 in_last;

  modport source (
    output valid, action, coef_index, coef_value, in_x, in_y, in_z, in_last,
    input  ready
  );
  modport sink (
    input  valid, action, coef_index, coef_value, in_x, in_y, in_z, in_last,
    output ready
  );
endinterface

// File: design/vat_out_if.sv
// ----------------------------------------------------------------------------
// vat_out_if
// Output channel: transformed vertices.
// ----------------------------------------------------------------------------
interface vat_out_if #(
  parameter int COORD_WIDTH = vat_pkg::COORD_WIDTH
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] out_x;
  logic signed [COORD_WIDTH-1:0] out_y;
  logic signed [COORD_WIDTH-1:0] out_z;
  logic                          overflow;
  logic                          out_last;

  modport source (
    output valid, out_x, out_y, out_z, overflow, out_last,
    input  ready
  );
  modport sink (
    input  valid, out_x, out_y, out_z, overflow, out_last,
    output ready
  );
endinterface

// File: design/vat_coef_store.sv
// ----------------------------------------------------------------------------
// vat_coef_store
// 4x4 column-major coefficient matrix, reset to identity.
// ----------------------------------------------------------------------------
module vat_coef_store #(
  parameter int COORD_WIDTH = vat_pkg::COORD_WIDTH,
  parameter int FRAC_BITS   = vat_pkg::FRAC_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           we,
  input  logic [vat_pkg::COEF_IDX_W-1:0] waddr,
  input  logic [COORD_WIDTH-1:0]         wdata,
  output logic [COORD_WIDTH-1:0]         coef [vat_pkg::NUM_COEF]
);

  // 1.0 in the fixed-point format, truncated to the coordinate width
  localparam logic [63:0]            ONE_WIDE = 64'(1) << FRAC_BITS;
  localparam logic [COORD_WIDTH-1:0] ONE      = ONE_WIDE[COORD_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < vat_pkg::NUM_COEF; i++) begin
        coef[i] <= (i % 5 == 0) ? ONE : '0;
      end
    end else if (we) begin
      coef[waddr] <= wdata;
    end
  end

endmodule

// File: design/vat_row.sv
// ----------------------------------------------------------------------------
// vat_row
// One output row: three products plus translation, shift and saturate.
// ----------------------------------------------------------------------------
module vat_row #(
  parameter int COORD_WIDTH = vat_pkg::COORD_WIDTH,
  parameter int FRAC_BITS   = vat_pkg::FRAC_BITS
) (
  input  logic                          clk,
  input  vat_pkg::vat_adv_t             adv,
  input  logic [COORD_WIDTH-1:0]        cx,
  input  logic [COORD_WIDTH-1:0]        cy,
  input  logic [COORD_WIDTH-1:0]        cz,
  input  logic [COORD_WIDTH-1:0]        ct,
  input  logic signed [COORD_WIDTH-1:0] x,
  input  logic signed [COORD_WIDTH-1:0] y,
  input  logic signed [COORD_WIDTH-1:0] z,
  output logic signed [COORD_WIDTH-1:0] res,
  output logic                          ovf
);

  localparam int CW   = COORD_WIDTH;
  localparam int LO_W = CW / 2;
  localparam int HI_W = CW - LO_W;
  localparam int PL_W = CW + LO_W + 1;
  localparam int PH_W = CW + HI_W;
  localparam int PW   = 2 * CW;
  localparam int AW   = ((2 * CW > CW + FRAC_BITS) ? 2 * CW : CW + FRAC_BITS) + 2;
  localparam int TOP  = FRAC_BITS + CW - 1;

  localparam logic signed [CW-1:0] MAXV = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] MINV = {1'b1, {(CW-1){1'b0}}};

  // stage 1: operands
  logic signed [CW-1:0]   v1 [3];
  logic        [CW-1:0]   c1 [3];
  logic signed [CW-1:0]   t1;
  // stage 2: partial products, coefficient split in halves
  logic signed [PL_W-1:0] pl2 [3];
  logic signed [PH_W-1:0] ph2 [3];
  logic signed [CW-1:0]   t2;
  // stage 3: full products, scaled translation
  logic signed [PW-1:0]   prod3 [3];
  logic signed [AW-1:0]   ts3;
  // stage 4: pair sums
  logic signed [AW-1:0]   sa4;
  logic signed [AW-1:0]   sb4;

  logic signed [AW-1:0]   acc;
  logic [AW-1-TOP:0]      upper;
  logic                   in_range;

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      v1[0] <= x;
      v1[1] <= y;
      v1[2] <= z;
      c1[0] <= cx;
      c1[1] <= cy;
      c1[2] <= cz;
      t1    <= $signed(ct);
    end
    if (adv.s2) begin
      for (int j = 0; j < 3; j++) begin
        pl2[j] <= PL_W'(v1[j]) * $signed({1'b0, c1[j][LO_W-1:0]});
        ph2[j] <= PH_W'(v1[j]) * PH_W'($signed(c1[j][CW-1:LO_W]));
      end
      t2 <= t1;
    end
    if (adv.s3) begin
      for (int j = 0; j < 3; j++) begin
        prod3[j] <= $signed({ph2[j], {LO_W{1'b0}}}) + PW'(pl2[j]);
      end
      ts3 <= AW'(t2) <<< FRAC_BITS;
    end
    if (adv.s4) begin
      sa4 <= AW'(prod3[0]) + AW'(prod3[1]);
      sb4 <= AW'(prod3[2]) + ts3;
    end
    if (adv.s5) begin
      res <= in_range ? $signed(acc[TOP:FRAC_BITS]) : (acc[AW-1] ? MINV : MAXV);
      ovf <= !in_range;
    end
  end

  // in range when all bits above the kept field match the sign
  always_comb begin
    acc      = sa4 + sb4;
    upper    = acc[AW-1:TOP];
    in_range = (&upper) || !(|upper);
  end

endmodule

// File: design/vertex_affine_transform.sv
// ----------------------------------------------------------------------------
// vertex_affine_transform
// Q-format 4x4 affine vertex transform with saturation, fully pipelined.
// ----------------------------------------------------------------------------
//   channel  dir  contents
//   vtx_in   in   action, coef_index, coef_value, in_x, in_y, in_z, in_last
//   vtx_out  out  out_x, out_y, out_z, overflow, out_last
//
// One word per cycle on vtx_in while the pipeline is not stalled. The edge that
// takes a vertex loads the operand stage, then partial product, product, pair
// sum and final sum/saturate follow before it is on vtx_out. A coefficient
// write lands in the matrix at once and applies to every later vertex; it
// gives no output word.
// Reset restores the identity matrix and empties the pipeline.
// Each stage has its own ready, so bubbles close up under an output stall.
// ----------------------------------------------------------------------------
module vertex_affine_transform #(
  parameter int COORD_WIDTH = vat_pkg::COORD_WIDTH,
  parameter int FRAC_BITS   = vat_pkg::FRAC_BITS
) (
  input  logic   clk,
  input  logic   rst,
  vat_in_if.sink   vtx_in,
  vat_out_if.source vtx_out
);

  logic [COORD_WIDTH-1:0] coef [vat_pkg::NUM_COEF];
  logic                   take;
  logic                   coef_we;
  logic                   xform_in;

  logic [5:1] vld;
  logic [5:1] rdy;
  logic [5:1] last;
  vat_pkg::vat_adv_t adv;

  logic signed [COORD_WIDTH-1:0] row_res [vat_pkg::NUM_ROWS];
  logic [vat_pkg::NUM_ROWS-1:0]  row_ovf;

  always_comb begin
    rdy[5] = !vld[5] || vtx_out.ready;
    for (int k = 4; k >= 1; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
    adv.s1 = rdy[1];
    adv.s2 = rdy[2];
    adv.s3 = rdy[3];
    adv.s4 = rdy[4];
    adv.s5 = rdy[5];
  end

  assign vtx_in.ready = rdy[1];
  assign take         = vtx_in.valid && rdy[1];
  assign coef_we      = take && (vtx_in.action == vat_pkg::ACTION_WRITE);
  assign xform_in     = take && (vtx_in.action == vat_pkg::ACTION_XFORM);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[1]) vld[1] <= xform_in;
      for (int k = 2; k <= 5; k++) begin
        if (rdy[k]) vld[k] <= vld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) last[1] <= vtx_in.in_last;
    for (int k = 2; k <= 5; k++) begin
      if (rdy[k]) last[k] <= last[k-1];
    end
  end

  vat_coef_store #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_coef (
    .clk   (clk),
    .rst   (rst),
    .we    (coef_we),
    .waddr (vtx_in.coef_index),
    .wdata (vtx_in.coef_value),
    .coef  (coef)
  );

  // row i takes column-major elements i, 4+i, 8+i and translation 12+i
  for (genvar i = 0; i < vat_pkg::NUM_ROWS; i++) begin : g_row
    vat_row #(
      .COORD_WIDTH (COORD_WIDTH),
      .FRAC_BITS   (FRAC_BITS)
    ) u_row (
      .clk (clk),
      .adv (adv),
      .cx  (coef[i]),
      .cy  (coef[4 + i]),
      .cz  (coef[8 + i]),
      .ct  (coef[12 + i]),
      .x   (vtx_in.in_x),
      .y   (vtx_in.in_y),
      .z   (vtx_in.in_z),
      .res (row_res[i]),
      .ovf (row_ovf[i])
    );
  end

  assign vtx_out.valid    = vld[5];
  assign vtx_out.out_x    = row_res[0];
  assign vtx_out.out_y    = row_res[1];
  assign vtx_out.out_z    = row_res[2];
  assign vtx_out.overflow = |row_ovf;
  assign vtx_out.out_last = last[5];

endmodule

// File: sim/vertex_affine_transform_test.sv
// ----------------------------------------------------------------------------
// vertex_affine_transform_test
// Self-checking bench for the fixed-point 4x4 vertex transform. A directed
// table covers identity, saturation in both directions, translation,
// truncation and the ignored w row. A long random stream follows, with
// coefficient writes mixed among vertices. Every output word is checked against
// the word written in the table or a local model of the matrix; both channels idle at random.
// ----------------------------------------------------------------------------
module vertex_affine_transform_test;
  import vat_pkg::*;

  localparam int ACC_W       = 2 * COORD_WIDTH + 4;
  localparam int N_RANDOM    = 650;
  localparam int HOLD_AT     = 325;
  localparam int RUN_LIMIT   = 1000000;

  localparam logic signed [COORD_WIDTH-1:0] Q_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] Q_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
  localparam logic signed [COORD_WIDTH-1:0] Q_ONE = COORD_WIDTH'(1) << FRAC_BITS;
  localparam logic signed [ACC_W-1:0] SAT_HI = (ACC_W'(1) << (COORD_WIDTH - 1)) - 1;
  localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - 1;

  typedef struct packed {
    logic                          action;
    logic [COEF_IDX_W-1:0]         coef_index;
    logic signed [COORD_WIDTH-1:0] coef_value;
    logic signed [COORD_WIDTH-1:0] in_x;
    logic signed [COORD_WIDTH-1:0] in_y;
    logic signed [COORD_WIDTH-1:0] in_z;
    logic                          in_last;
  } vtx_word_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] out_x;
    logic signed [COORD_WIDTH-1:0] out_y;
    logic signed [COORD_WIDTH-1:0] out_z;
    logic                          overflow;
    logic                          out_last;
  } xform_result_t;

  // typed = 1: the expected word is written in the row, not predicted
  typedef struct {
    vtx_word_t     word;
    bit            typed;
    xform_result_t res;
  } dir_row_t;

  logic clk;
  logic rst;

  vat_in_if  vin ();
  vat_out_if vout ();

  vertex_affine_transform u_top (
    .clk     (clk),
    .rst     (rst),
    .vtx_in  (vin),
    .vtx_out (vout)
  );

  logic signed [COORD_WIDTH-1:0] coef_mat [NUM_COEF];
  xform_result_t pending_xforms [$];
  dir_row_t      dir_rows [$];

  int  err_count;
  int  n_writes;
  int  n_vertices;
  int  n_checked;
  int  n_sat;
  int  item_no;
  bit  calm;
  bit [NUM_COEF-1:0] idx_hit;

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #(RUN_LIMIT);
    $display("vertex_affine_transform_test: errors");
    $finish;
  end

  // Exact row sums, floor shift, clamp to the coordinate width.
  function automatic xform_result_t transform_vertex(input vtx_word_t w);
    logic signed [COORD_WIDTH-1:0] crd [3];
    logic signed [COORD_WIDTH-1:0] row [3];
    logic signed [ACC_W-1:0]       acc;
    logic signed [ACC_W-1:0]       a;
    logic signed [ACC_W-1:0]       b;
    xform_result_t                 r;
    crd[0] = w.in_x;
    crd[1] = w.in_y;
    crd[2] = w.in_z;
    r = '0;
    for (int i = 0; i < NUM_ROWS; i++) begin
      acc = coef_mat[12 + i];
      acc = acc <<< FRAC_BITS;
      for (int j = 0; j < 3; j++) begin
        a = coef_mat[j * 4 + i];
        b = crd[j];
        acc = acc + a * b;
      end
      acc = acc >>> FRAC_BITS;
      if (acc > SAT_HI) begin
        row[i] = Q_MAX;
        r.overflow = 1'b1;
      end else if (acc < SAT_LO) begin
        row[i] = Q_MIN;
        r.overflow = 1'b1;
      end else begin
        row[i] = acc[COORD_WIDTH-1:0];
      end
    end
    r.out_x = row[0];
    r.out_y = row[1];
    r.out_z = row[2];
    r.out_last = w.in_last;
    return r;
  endfunction

  function automatic vtx_word_t mk_xform(input logic signed [COORD_WIDTH-1:0] x, y, z,
                                         input logic last);
    vtx_word_t w;
    w = '{ACTION_XFORM, 4'hF, 32'h5A5A_A5A5, x, y, z, last};
    return w;
  endfunction

  // vertex fields carry junk on purpose; the block must ignore them
  function automatic vtx_word_t mk_write(input logic [COEF_IDX_W-1:0] idx,
                                         input logic signed [COORD_WIDTH-1:0] val);
    vtx_word_t w;
    w = '{ACTION_WRITE, idx, val, 32'hDEAD_BEEF, 32'h1234_5678, 32'hFFFF_0001, 1'b1};
    return w;
  endfunction

  function automatic xform_result_t mk_res(input logic signed [COORD_WIDTH-1:0] x, y, z,
                                           input logic ovf, last);
    xform_result_t r;
    r = '{x, y, z, ovf, last};
    return r;
  endfunction

  // extremes, zero, one, full-range noise, or values scaled down by sh bits
  function automatic logic signed [COORD_WIDTH-1:0] rand_fix(input int sh);
    logic signed [COORD_WIDTH-1:0] v;
    case ($urandom_range(0, 9))
      0: v = Q_MAX;
      1: v = Q_MIN;
      2: v = '0;
      3: v = Q_ONE;
      4, 5: v = $urandom;
      default: v = $signed($urandom) >>> sh;
    endcase
    return v;
  endfunction

  function automatic vtx_word_t rand_word();
    vtx_word_t w;
    w.action     = ($urandom_range(0, 3) == 0) ? ACTION_WRITE : ACTION_XFORM;
    w.coef_index = $urandom_range(0, NUM_COEF - 1);
    w.coef_value = rand_fix(13);
    w.in_x       = rand_fix(8);
    w.in_y       = rand_fix(8);
    w.in_z       = rand_fix(8);
    w.in_last    = ($urandom_range(0, 7) == 0);
    return w;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // Present one word, wait for the handshake, then update the model.
  // hold: drop valid until every pending vertex has come back.
  task automatic send_word(input vtx_word_t w, input bit typed, input xform_result_t res,
                           input bit hold);
    int gap;
    gap = pick_gap();
    if (hold && gap == 0) gap = 1;
    if (gap > 0) begin
      vin.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      while (hold && pending_xforms.size() != 0) @(posedge clk);
    end
    vin.valid      <= 1'b1;
    vin.action     <= w.action;
    vin.coef_index <= w.coef_index;
    vin.coef_value <= w.coef_value;
    vin.in_x       <= w.in_x;
    vin.in_y       <= w.in_y;
    vin.in_z       <= w.in_z;
    vin.in_last    <= w.in_last;
    do @(posedge clk); while (!vin.ready);
    if (w.action == ACTION_WRITE) begin
      coef_mat[w.coef_index] = w.coef_value;
      idx_hit[w.coef_index] = 1'b1;
      n_writes++;
    end else begin
      pending_xforms.push_back(typed ? res : transform_vertex(w));
      n_vertices++;
    end
  endtask

  task automatic check_field(input string name, input logic [COORD_WIDTH-1:0] want, got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    xform_result_t want;
    if (!rst && vout.valid && vout.ready) begin
      if (pending_xforms.size() == 0) begin
        $display("%0t: unexpected output word, expected none, got %h %h %h ovf=%b last=%b",
                 $time, vout.out_x, vout.out_y, vout.out_z, vout.overflow, vout.out_last);
        err_count++;
      end else begin
        want = pending_xforms.pop_front();
        check_field("out_x", want.out_x, vout.out_x);
        check_field("out_y", want.out_y, vout.out_y);
        check_field("out_z", want.out_z, vout.out_z);
        check_field("overflow", want.overflow, vout.overflow);
        check_field("out_last", want.out_last, vout.out_last);
        n_checked++;
        if (want.overflow) n_sat++;
      end
    end
  end

  // Output side: short and long stalls, with long stretches of steady ready.
  initial begin
    vout.ready = 1'b0;
    forever begin
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) begin
        vout.ready <= 1'b0;
        repeat ($urandom_range(10, 40)) @(posedge clk);
      end else if (r < 45) begin
        vout.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
      vout.ready <= 1'b1;
      if (r >= 90) repeat ($urandom_range(50, 150)) @(posedge clk);
      else repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  initial begin
    rst            = 1'b1;
    vin.valid      = 1'b0;
    vin.action     = ACTION_XFORM;
    vin.coef_index = '0;
    vin.coef_value = '0;
    vin.in_x       = '0;
    vin.in_y       = '0;
    vin.in_z       = '0;
    vin.in_last    = 1'b0;
    err_count  = 0;
    n_writes   = 0;
    n_vertices = 0;
    n_checked  = 0;
    n_sat      = 0;
    idx_hit    = '0;
    calm       = 1'b0;
    for (int i = 0; i < NUM_COEF; i++)
      coef_mat[i] = (i % 5 == 0) ? Q_ONE : '0;

    // identity passes coordinates through untouched
    dir_rows.push_back('{mk_xform(Q_MAX, Q_MIN, 0, 1), 1'b1, mk_res(Q_MAX, Q_MIN, 0, 0, 1)});
    dir_rows.push_back('{mk_xform(32'sh0001_8000, -2 * Q_ONE, 1, 0), 1'b1,
                         mk_res(32'sh0001_8000, -2 * Q_ONE, 1, 0, 0)});
    // saturation high and low through the x scale
    dir_rows.push_back('{mk_write(0, Q_MAX), 1'b0, '0});
    dir_rows.push_back('{mk_xform(Q_MAX, 0, 0, 0), 1'b1, mk_res(Q_MAX, 0, 0, 1, 0)});
    dir_rows.push_back('{mk_xform(Q_MIN, 0, 0, 1), 1'b1, mk_res(Q_MIN, 0, 0, 1, 1)});
    dir_rows.push_back('{mk_write(0, Q_MIN), 1'b0, '0});
    dir_rows.push_back('{mk_xform(Q_MIN, Q_ONE, 0, 0), 1'b1, mk_res(Q_MAX, Q_ONE, 0, 1, 0)});
    // half scale on a tiny negative: shift rounds toward minus infinity
    dir_rows.push_back('{mk_write(0, Q_ONE / 2), 1'b0, '0});
    dir_rows.push_back('{mk_xform(-1, 0, 0, 0), 1'b0, '0});
    // translation at the limits
    dir_rows.push_back('{mk_write(0, Q_ONE), 1'b0, '0});
    dir_rows.push_back('{mk_write(12, Q_MAX), 1'b0, '0});
    dir_rows.push_back('{mk_xform(0, 0, 0, 0), 1'b1, mk_res(Q_MAX, 0, 0, 0, 0)});
    dir_rows.push_back('{mk_xform(Q_ONE, 0, 0, 1), 1'b1, mk_res(Q_MAX, 0, 0, 1, 1)});
    dir_rows.push_back('{mk_write(12, Q_MIN), 1'b0, '0});
    dir_rows.push_back('{mk_xform(-Q_ONE, 0, 0, 0), 1'b1, mk_res(Q_MIN, 0, 0, 1, 0)});
    // w row is stored but must not affect anything
    dir_rows.push_back('{mk_write(3, Q_MAX), 1'b0, '0});
    dir_rows.push_back('{mk_write(15, 0), 1'b0, '0});
    dir_rows.push_back('{mk_write(13, 2 * Q_ONE), 1'b0, '0});
    dir_rows.push_back('{mk_write(14, -Q_ONE), 1'b0, '0});
    dir_rows.push_back('{mk_write(12, 0), 1'b0, '0});
    dir_rows.push_back('{mk_write(4, -3 * Q_ONE), 1'b0, '0});
    dir_rows.push_back('{mk_xform(5 * Q_ONE, 7 * Q_ONE, -Q_ONE / 4, 1), 1'b0, '0});
    dir_rows.push_back('{mk_write(10, Q_MIN), 1'b0, '0});
    dir_rows.push_back('{mk_xform(0, Q_MIN, Q_MIN, 1), 1'b0, '0});

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i])
      send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].res, 1'b0);

    for (item_no = 0; item_no < N_RANDOM; item_no++) begin
      calm = (item_no % 128) < 24;
      send_word(rand_word(), 1'b0, '0, item_no == 0 || item_no == HOLD_AT);
    end
    vin.valid <= 1'b0;

    while (pending_xforms.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("Sent %0d coefficient writes and %0d vertices; %0d results checked.",
             n_writes, n_vertices, n_checked);
    $display("%0d results saturated; coefficient indices written: %b.", n_sat, idx_hit);
    if (err_count == 0)
      $display("vertex_affine_transform_test: clean");
    else
      $display("vertex_affine_transform_test: errors");
    $finish;
  end

endmodule
